[hw/rtl/tfa_pkg.sv]
// ----------------------------------------------------------------------------
// tfa_pkg: shared types and constants of the temporal frame averager
// Register indexes, mode codes, field widths and the item handed from the
// accumulator to the divider pipeline.
// ----------------------------------------------------------------------------
package tfa_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 32;
  localparam int DIV_W       = SUM_W + 1;
  localparam int MODE_W      = 2;
  localparam int WIN_CFG_W   = 5;
  localparam int FRAME_CFG_W = 13;
  localparam int CFG_DATA_W  = FRAME_CFG_W;
  localparam int CFG_IDX_W   = 2;

  localparam int MAX_FRAME_SAMPLES_DEF = 4096;
  localparam int MAX_WINDOW_DEF        = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AVERAGE_MODE  = 2'd0,
    REG_WINDOW_FRAMES = 2'd1,
    REG_FRAME_SAMPLES = 2'd2,
    REG_WIDE_SAMPLES  = 2'd3
  } cfg_reg_e;

  localparam logic [MODE_W-1:0] MODE_FADE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WINDOW = 2'd2;

  localparam logic [MODE_W-1:0]      MODE_RST   = 2'd0;
  localparam logic [WIN_CFG_W-1:0]   WINDOW_RST = 5'd10;
  localparam logic [FRAME_CFG_W-1:0] FRAME_RST  = 13'd4096;

  typedef struct packed {
    logic [MODE_W-1:0]      average_mode;
    logic [WIN_CFG_W-1:0]   window_frames;
    logic [FRAME_CFG_W-1:0] frame_samples;
    logic                   wide_samples;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
    logic             wide;
    logic             last;
  } div_item_t;

endpackage

[hw/rtl/tfa_if.sv]
// ----------------------------------------------------------------------------
// tfa_if: stream interfaces of the temporal frame averager
// Sample input channel and averaged result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tfa_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface tfa_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] average_out;
  logic        frame_end;

  modport source (output valid, output average_out, output frame_end, input ready);
  modport sink (input valid, input average_out, input frame_end, output ready);
endinterface

[hw/rtl/temporal_frame_averager.sv]
// ----------------------------------------------------------------------------
// temporal_frame_averager: per-position average of a video sample stream
// Top level: configuration registers, pipeline enable and stream channels.
// ----------------------------------------------------------------------------
// The block takes one sample per clock in frame order and returns one averaged
// sample per input sample, in the same order. The rate is one transfer per
// cycle while the sink is ready; it is set by the per-position sum store
// (one read and one write each cycle, with a bypass when a frame is only one
// sample long) and by a 32-stage divider that makes one quotient bit a stage.
// The whole pipeline advances together: it stalls only while a result sits in
// the output stage and the sink is not ready. Any configuration write restarts
// averaging, and the next sample is taken as position 0 of the first frame;
// write registers only while the pipeline is empty. The first frame after a
// restart passes through unchanged.
// ----------------------------------------------------------------------------
module temporal_frame_averager
  import tfa_pkg::*;
#(
  parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF,
  parameter int MAX_WINDOW        = MAX_WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tfa_in_if.sink                src_i,
  tfa_out_if.source             res_o
);

  cfg_t cfg_q;
  logic en;
  logic accept;
  div_item_t div_item;

  // Configuration registers. Every write restarts averaging downstream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.average_mode  <= MODE_RST;
      cfg_q.window_frames <= WINDOW_RST;
      cfg_q.frame_samples <= FRAME_RST;
      cfg_q.wide_samples  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_AVERAGE_MODE:  cfg_q.average_mode  <= cfg_data_i[MODE_W-1:0];
        REG_WINDOW_FRAMES: cfg_q.window_frames <= cfg_data_i[WIN_CFG_W-1:0];
        REG_FRAME_SAMPLES: cfg_q.frame_samples <= cfg_data_i[FRAME_CFG_W-1:0];
        REG_WIDE_SAMPLES:  cfg_q.wide_samples  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output stage is empty or being drained.
  assign en          = !res_o.valid || res_o.ready;
  assign src_i.ready = en;
  assign accept      = src_i.valid && en;

  tfa_accum #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES),
    .MAX_WINDOW        (MAX_WINDOW)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .restart_i (cfg_we_i),
    .cfg_i     (cfg_q),
    .accept_i  (accept),
    .sample_i  (src_i.sample_in),
    .div_o     (div_item)
  );

  // The divider's last stage doubles as the output register.
  tfa_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .div_i   (div_item),
    .valid_o (res_o.valid),
    .quot_o  (res_o.average_out),
    .last_o  (res_o.frame_end)
  );

endmodule

[hw/rtl/tfa_accum.sv]
// ----------------------------------------------------------------------------
// tfa_accum: position counters, stores and running-sum update
// Stage 0 reads the per-position sum and window sample, stage 1 updates and
// writes them back, stage 2 holds the quotient job for the divider.
// ----------------------------------------------------------------------------
module tfa_accum
  import tfa_pkg::*;
#(
  parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF,
  parameter int MAX_WINDOW        = MAX_WINDOW_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                restart_i,
  input  cfg_t                cfg_i,
  input  logic                accept_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output div_item_t           div_o
);

  localparam int PW    = $clog2(MAX_FRAME_SAMPLES);
  localparam int SW    = $clog2(MAX_WINDOW);
  localparam int DEPTH = MAX_FRAME_SAMPLES * MAX_WINDOW;
  localparam int AW    = $clog2(DEPTH);
  localparam int FCW   = (PW + 1 > FRAME_CFG_W) ? PW + 1 : FRAME_CFG_W;
  localparam int WNW   = $clog2(MAX_WINDOW + 1);
  localparam int WCW   = (WNW > WIN_CFG_W) ? WNW : WIN_CFG_W;

  logic [SUM_W-1:0]    sums_mem [MAX_FRAME_SAMPLES];
  logic [SAMPLE_W-1:0] win_mem  [DEPTH];

  logic [PW-1:0]    pos_q, pos_d;
  logic [SW-1:0]    slot_q, slot_d;
  logic [SUM_W-1:0] fs_q, fs_d;

  logic [FCW-1:0] fs_ext, f_eff;
  logic [WCW-1:0] nw_ext, n_eff;
  logic [PW-1:0]  p_cur;
  logic [SW-1:0]  slot_cur, slot_nxt;
  logic [AW-1:0]  widx;
  logic           last, first, full;
  logic [DIV_W-1:0]    div_cur;
  logic [SAMPLE_W-1:0] s_masked;

  // Stage 1 payload
  logic                s1_valid_q;
  logic [SAMPLE_W-1:0] s1_s_q;
  logic [PW-1:0]       s1_p_q;
  logic [AW-1:0]       s1_widx_q;
  logic                s1_first_q, s1_full_q, s1_last_q, s1_wide_q;
  logic [MODE_W-1:0]   s1_mode_q;
  logic [DIV_W-1:0]    s1_div_q;
  logic [SUM_W-1:0]    sum_rd_q;
  logic [SAMPLE_W-1:0] win_rd_q;

  // Write-back bypass for the item that follows at the same address
  logic                sb_vld_q, wb_vld_q;
  logic [PW-1:0]       sb_addr_q;
  logic [AW-1:0]       wb_addr_q;
  logic [SUM_W-1:0]    sb_data_q;
  logic [SAMPLE_W-1:0] wb_data_q;

  logic [SUM_W-1:0]    sum_old, sum_new, s32, fade_tmp;
  logic [SAMPLE_W-1:0] win_old;
  logic                win_we;

  div_item_t s2_q;

  always_comb begin
    fs_ext = FCW'(cfg_i.frame_samples);
    if (fs_ext == '0) begin
      f_eff = FCW'(1);
    end else if (fs_ext > FCW'(MAX_FRAME_SAMPLES)) begin
      f_eff = FCW'(MAX_FRAME_SAMPLES);
    end else begin
      f_eff = fs_ext;
    end
    nw_ext = WCW'(cfg_i.window_frames);
    if (nw_ext == '0) begin
      n_eff = WCW'(1);
    end else if (nw_ext > WCW'(MAX_WINDOW)) begin
      n_eff = WCW'(MAX_WINDOW);
    end else begin
      n_eff = nw_ext;
    end

    p_cur    = (FCW'(pos_q) >= f_eff) ? '0 : pos_q;
    slot_cur = (WCW'(slot_q) >= n_eff) ? '0 : slot_q;
    last     = (FCW'(p_cur) + FCW'(1)) >= f_eff;
    slot_nxt = ((WCW'(slot_cur) + WCW'(1)) >= n_eff) ? '0 : SW'(slot_cur + SW'(1));
    widx     = AW'(slot_cur) * AW'(MAX_FRAME_SAMPLES) + AW'(p_cur);
    first    = (fs_q == '0);
    full     = fs_q >= SUM_W'(n_eff);
    s_masked = cfg_i.wide_samples ? sample_i : {8'h00, sample_i[7:0]};

    if (first || cfg_i.average_mode == MODE_FADE) begin
      div_cur = DIV_W'(1);
    end else if (cfg_i.average_mode == MODE_WINDOW && full) begin
      div_cur = DIV_W'(n_eff);
    end else begin
      div_cur = {1'b0, fs_q} + DIV_W'(1);
    end

    pos_d  = pos_q;
    slot_d = slot_q;
    fs_d   = fs_q;
    if (restart_i) begin
      pos_d  = '0;
      slot_d = '0;
      fs_d   = '0;
    end else if (accept_i) begin
      if (last) begin
        pos_d  = '0;
        slot_d = slot_nxt;
        fs_d   = (fs_q == '1) ? fs_q : fs_q + SUM_W'(1);
      end else begin
        pos_d  = PW'(p_cur + PW'(1));
        slot_d = slot_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      slot_q <= '0;
      fs_q   <= '0;
    end else begin
      pos_q  <= pos_d;
      slot_q <= slot_d;
      fs_q   <= fs_d;
    end
  end

  // Stage 0: capture the item and read both stores.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && accept_i) begin
      s1_s_q     <= s_masked;
      s1_p_q     <= p_cur;
      s1_widx_q  <= widx;
      s1_first_q <= first;
      s1_full_q  <= full;
      s1_last_q  <= last;
      s1_wide_q  <= cfg_i.wide_samples;
      s1_mode_q  <= cfg_i.average_mode;
      s1_div_q   <= div_cur;
      sum_rd_q   <= sums_mem[p_cur];
      win_rd_q   <= win_mem[widx];
    end
  end

  // Stage 1: update the sum and write it back.
  always_comb begin
    sum_old  = (sb_vld_q && sb_addr_q == s1_p_q) ? sb_data_q : sum_rd_q;
    win_old  = (wb_vld_q && wb_addr_q == s1_widx_q) ? wb_data_q : win_rd_q;
    s32      = SUM_W'(s1_s_q);
    fade_tmp = sum_old + {sum_old[SUM_W-2:0], 1'b0} + s32;
    win_we   = s1_first_q || s1_mode_q == MODE_WINDOW;
    priority if (s1_first_q) begin
      sum_new = s32;
    end else if (s1_mode_q == MODE_FADE) begin
      sum_new = {2'b00, fade_tmp[SUM_W-1:2]};
    end else if (s1_mode_q == MODE_WINDOW) begin
      sum_new = sum_old - (s1_full_q ? SUM_W'(win_old) : '0) + s32;
    end else begin
      sum_new = sum_old + s32;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && s1_valid_q) begin
      sums_mem[s1_p_q] <= sum_new;
      if (win_we) begin
        win_mem[s1_widx_q] <= s1_s_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_vld_q <= 1'b0;
      wb_vld_q <= 1'b0;
    end else if (restart_i) begin
      sb_vld_q <= 1'b0;
      wb_vld_q <= 1'b0;
    end else if (en_i) begin
      sb_vld_q <= s1_valid_q;
      wb_vld_q <= s1_valid_q && win_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_addr_q <= s1_p_q;
      sb_data_q <= sum_new;
      wb_addr_q <= s1_widx_q;
      wb_data_q <= s1_s_q;
    end
  end

  // Stage 2: quotient job for the divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (en_i) begin
      s2_q.valid    <= s1_valid_q;
      s2_q.dividend <= sum_new;
      s2_q.divisor  <= s1_div_q;
      s2_q.wide     <= s1_wide_q;
      s2_q.last     <= s1_last_q;
    end
  end

  assign div_o = s2_q;

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FCW'(pos_q) < f_eff) else $error("sample position beyond frame length");

  a_first_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && s1_valid_q && s1_first_q) |=> (s2_q.valid && s2_q.divisor == DIV_W'(1)))
    else $error("first frame sample not passed through");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> (fs_q == '0 && pos_q == '0 && slot_q == '0))
    else $error("register write did not restart averaging");

endmodule

[hw/rtl/tfa_divider.sv]
// ----------------------------------------------------------------------------
// tfa_divider: pipelined restoring divider
// One quotient bit per stage; the last stage is the output register.
// ----------------------------------------------------------------------------
module tfa_divider
  import tfa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  div_item_t           div_i,
  output logic                valid_o,
  output logic [SAMPLE_W-1:0] quot_o,
  output logic                last_o
);

  localparam int STAGES = SUM_W;

  typedef struct packed {
    logic             valid;
    logic [DIV_W-1:0] rem;
    logic [SUM_W-1:0] num;
    logic [DIV_W-1:0] divisor;
    logic             wide;
    logic             last;
  } stage_t;

  stage_t stage_q [STAGES];
  stage_t stage_d [STAGES];

  always_comb begin
    stage_t    prev;
    logic [DIV_W:0] t;
    logic      ge;
    for (int i = 0; i < STAGES; i++) begin
      if (i == 0) begin
        prev.valid   = div_i.valid;
        prev.rem     = '0;
        prev.num     = div_i.dividend;
        prev.divisor = div_i.divisor;
        prev.wide    = div_i.wide;
        prev.last    = div_i.last;
      end else begin
        prev = stage_q[i-1];
      end
      t  = {prev.rem, prev.num[SUM_W-1]};
      ge = t >= {1'b0, prev.divisor};
      stage_d[i]       = prev;
      stage_d[i].rem   = ge ? DIV_W'(t - {1'b0, prev.divisor}) : t[DIV_W-1:0];
      stage_d[i].num   = {prev.num[SUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STAGES; i++) begin
        stage_q[i] <= '0;
      end
    end else if (en_i) begin
      for (int i = 0; i < STAGES; i++) begin
        stage_q[i] <= stage_d[i];
      end
    end
  end

  assign valid_o = stage_q[STAGES-1].valid;
  assign last_o  = stage_q[STAGES-1].last;
  assign quot_o  = stage_q[STAGES-1].wide ? stage_q[STAGES-1].num[SAMPLE_W-1:0]
                                          : {8'h00, stage_q[STAGES-1].num[7:0]};

endmodule
